FILE: rtl/assert_macros.svh
// Assertion macros; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/spfl_pkg.sv
package spfl_pkg;

    localparam int NUM_SERVERS = 8;
    localparam int IDX_W       = $clog2(NUM_SERVERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 32;
    localparam int ACC_W       = 48;
    localparam int SRV_W       = 32;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SRV_W-1:0]        SRV_MAX = {SRV_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_REPORT  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_ASSIGNED  = 3'd0,
        STAT_NONE_FREE = 3'd1,
        STAT_RELEASED  = 3'd2,
        STAT_REJECTED  = 3'd3,
        STAT_REPORT    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SVC,
        ST_GAP,
        ST_NONE,
        ST_REL,
        ST_RPT
    } state_t;

    typedef enum logic [1:0] {
        SEL_SVC,
        SEL_GAP,
        SEL_RPT
    } unit_sel_t;

    // sequencer -> datapath
    typedef struct packed {
        logic             in_ready;
        logic             cfg_ready;
        logic             pop;
        logic             push;
        logic             wr_svc;
        logic             wr_gap;
        logic             wr_rpt;
        logic             out_load;
        logic             out_last;
        unit_sel_t        unit_sel;
        status_t          out_status;
        logic [IDX_W-1:0] row;
    } ctl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic             accept;
        cmd_t             cmd;
        logic             fifo_empty;
        logic             release_ok;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } sts_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = v;
        if (c == '0)
            c = CNT_W'(1);
        if (c > CNT_W'(NUM_SERVERS))
            c = CNT_W'(NUM_SERVERS);
        return c;
    endfunction

endpackage

FILE: rtl/spfl_sat_acc.sv
// Shared saturating accumulate: sum = sat48(acc + add_term - sub_term)
module spfl_sat_acc (
    input  logic signed [spfl_pkg::ACC_W-1:0]  acc,
    input  logic        [spfl_pkg::TIME_W-1:0] add_term,
    input  logic        [spfl_pkg::TIME_W-1:0] sub_term,
    output logic signed [spfl_pkg::ACC_W-1:0]  sum
);
    import spfl_pkg::*;

    localparam int EXT_W = ACC_W + 2;

    logic signed [EXT_W-1:0] wide;
    logic                    ovf;

    assign wide = EXT_W'(acc) + $signed(EXT_W'(add_term)) - $signed(EXT_W'(sub_term));
    // top three bits must agree for the result to fit in ACC_W bits
    assign ovf  = (wide[EXT_W-1:ACC_W-1] != '0) && (wide[EXT_W-1:ACC_W-1] != '1);

    always_comb
    begin
        if (!ovf)
            sum = wide[ACC_W-1:0];
        else if (wide[EXT_W-1])
            sum = ACC_MIN;
        else
            sum = ACC_MAX;
    end

endmodule

FILE: rtl/spfl_free_fifo.sv
// Circular free list of server indices
module spfl_free_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        refill,
    input  logic [spfl_pkg::CNT_W-1:0]  refill_count,
    input  logic                        push,
    input  logic [spfl_pkg::IDX_W-1:0]  push_idx,
    input  logic                        pop,
    output logic [spfl_pkg::IDX_W-1:0]  head_idx,
    output logic [spfl_pkg::CNT_W-1:0]  free_count
);
    import spfl_pkg::*;

    logic [IDX_W-1:0] fifo_reg [NUM_SERVERS];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] free_reg;

    assign head_idx   = fifo_reg[head_reg];
    assign free_count = free_reg;

    // Entries past the count are never read before they are written,
    // so a refill can load every slot with its own index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
                fifo_reg[i] <= IDX_W'(i);
            head_reg <= '0;
            tail_reg <= IDX_W'(NUM_SERVERS % NUM_SERVERS);
            free_reg <= CNT_W'(NUM_SERVERS);
        end
        else if (refill)
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
                fifo_reg[i] <= IDX_W'(i);
            head_reg <= '0;
            tail_reg <= IDX_W'(refill_count % NUM_SERVERS);
            free_reg <= refill_count;
        end
        else if (push)
        begin
            fifo_reg[tail_reg] <= push_idx;
            tail_reg           <= tail_reg + IDX_W'(1);
            free_reg           <= free_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            head_reg <= head_reg + IDX_W'(1);
            free_reg <= free_reg - CNT_W'(1);
        end
    end

endmodule

FILE: rtl/spfl_ctrl.sv
// Command sequencer
module spfl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  spfl_pkg::sts_t sts,
    output spfl_pkg::ctl_t ctl
);
    import spfl_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] row_next;
    logic             row_last;

    assign row_last = (CNT_W'(row_reg) + CNT_W'(1)) == sts.count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.accept)
                begin
                    case (sts.cmd)
                        CMD_ASSIGN:  state_next = sts.fifo_empty ? ST_NONE : ST_SVC;
                        CMD_RELEASE: state_next = ST_REL;
                        CMD_REPORT:  state_next = ST_RPT;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SVC:
                state_next = ST_GAP;
            ST_GAP, ST_NONE, ST_REL:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            ST_RPT:
            begin
                if (sts.out_free)
                begin
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                        row_next   = '0;
                    end
                    else
                        row_next = row_reg + IDX_W'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        ctl.unit_sel   = SEL_SVC;
        ctl.out_status = STAT_ASSIGNED;
        ctl.row        = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready  = 1'b1;
                ctl.cfg_ready = 1'b1;
            end
            ST_SVC:
            begin
                ctl.pop      = 1'b1;
                ctl.wr_svc   = 1'b1;
                ctl.unit_sel = SEL_SVC;
            end
            ST_GAP:
            begin
                ctl.unit_sel   = SEL_GAP;
                ctl.out_status = STAT_ASSIGNED;
                ctl.out_last   = 1'b1;
                ctl.wr_gap     = sts.out_free;
                ctl.out_load   = sts.out_free;
            end
            ST_NONE:
            begin
                ctl.out_status = STAT_NONE_FREE;
                ctl.out_last   = 1'b1;
                ctl.out_load   = sts.out_free;
            end
            ST_REL:
            begin
                ctl.out_status = sts.release_ok ? STAT_RELEASED : STAT_REJECTED;
                ctl.out_last   = 1'b1;
                ctl.out_load   = sts.out_free;
                ctl.push       = sts.out_free && sts.release_ok;
            end
            ST_RPT:
            begin
                ctl.unit_sel   = SEL_RPT;
                ctl.out_status = STAT_REPORT;
                ctl.out_last   = row_last;
                ctl.wr_rpt     = sts.out_free;
                ctl.out_load   = sts.out_free;
            end
            default:
            begin
                ctl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/server_pool_free_list_with_stats.sv
// Server pool allocator with per-server statistics. Commands come in on the
// s_ stream (cmd in s_tuser); results leave on the m_ stream, one transaction
// per command but a nop, or one row per active server for a report, with
// m_tlast on the final row. The block takes one command at a time: an assign
// passes service and idle-total states, a release or a rejected assign a
// result state, a report a row state per server; an m_ stall holds all but
// the service state. Idle and service totals use one 48-bit saturating
// accumulator: twice per assign (service, then idle total), once per row.
// cfg_data (server_count) is taken only while no command is in progress; it is
// clamped to 1..8 and refills the free list with 0..count-1, keeping statistics.
`include "assert_macros.svh"

module server_pool_free_list_with_stats (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] server_index, [34:3] svc_start, [66:35] svc_end,
    // [98:67] report_time, [103:99] zero
    input  logic [103:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] server_id, [50:3] idle_total, [98:51] service_total,
    // [130:99] served_count, [135:131] zero
    output logic [135:0] m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data
);
    import spfl_pkg::*;

    ctl_t ctl;
    sts_t sts;

    logic             in_accept;
    logic             cfg_accept;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cfg_count;

    logic [IDX_W-1:0]  sidx_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] finish_reg;
    logic [TIME_W-1:0] report_reg;
    logic [IDX_W-1:0]  srv_reg;

    logic [IDX_W-1:0] head_idx;
    logic [CNT_W-1:0] free_count;

    logic [TIME_W-1:0]       last_finish_reg [NUM_SERVERS];
    logic signed [ACC_W-1:0] idle_acc_reg    [NUM_SERVERS];
    logic signed [ACC_W-1:0] service_acc_reg [NUM_SERVERS];
    logic [SRV_W-1:0]        served_reg      [NUM_SERVERS];

    logic signed [ACC_W-1:0] unit_acc;
    logic [TIME_W-1:0]       unit_add;
    logic [TIME_W-1:0]       unit_sub;
    logic signed [ACC_W-1:0] unit_sum;
    logic [SRV_W-1:0]        served_inc;

    logic                    m_tvalid_reg;
    status_t                 status_reg;
    logic [IDX_W-1:0]        id_reg;
    logic signed [ACC_W-1:0] idle_out_reg;
    logic signed [ACC_W-1:0] service_out_reg;
    logic [SRV_W-1:0]        served_out_reg;
    logic                    last_reg;

    logic [IDX_W-1:0]        id_next;
    logic signed [ACC_W-1:0] idle_out_next;
    logic signed [ACC_W-1:0] service_out_next;
    logic [SRV_W-1:0]        served_out_next;

    assign s_tready   = ctl.in_ready;
    assign cfg_ready  = ctl.cfg_ready;
    assign in_accept  = s_tvalid && ctl.in_ready;
    assign cfg_accept = cfg_valid && ctl.cfg_ready;
    assign cfg_count  = clamp_count(cfg_data);

    assign sts.accept     = in_accept;
    assign sts.cmd        = cmd_t'(s_tuser);
    assign sts.fifo_empty = (free_count == '0);
    assign sts.release_ok = (CNT_W'(sidx_reg) < count_reg) && (free_count < count_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;
    assign sts.count      = count_reg;

    spfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    spfl_free_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .refill       (cfg_accept),
        .refill_count (cfg_count),
        .push         (ctl.push),
        .push_idx     (sidx_reg),
        .pop          (ctl.pop),
        .head_idx     (head_idx),
        .free_count   (free_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CNT_W'(NUM_SERVERS);
        else if (cfg_accept)
            count_reg <= cfg_count;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sidx_reg   <= s_tdata[2:0];
            start_reg  <= s_tdata[34:3];
            finish_reg <= s_tdata[66:35];
            report_reg <= s_tdata[98:67];
        end
        if (ctl.pop)
            srv_reg <= head_idx;
    end

    // operand select for the shared accumulator
    always_comb
    begin
        case (ctl.unit_sel)
            SEL_SVC:
            begin
                unit_acc = service_acc_reg[head_idx];
                unit_add = finish_reg;
                unit_sub = start_reg;
            end
            SEL_GAP:
            begin
                unit_acc = idle_acc_reg[srv_reg];
                unit_add = start_reg;
                unit_sub = last_finish_reg[srv_reg];
            end
            SEL_RPT:
            begin
                unit_acc = idle_acc_reg[ctl.row];
                unit_add = report_reg;
                unit_sub = last_finish_reg[ctl.row];
            end
            default:
            begin
                unit_acc = '0;
                unit_add = '0;
                unit_sub = '0;
            end
        endcase
    end

    spfl_sat_acc u_acc (
        .acc      (unit_acc),
        .add_term (unit_add),
        .sub_term (unit_sub),
        .sum      (unit_sum)
    );

    assign served_inc = (served_reg[srv_reg] == SRV_MAX) ? SRV_MAX
                                                         : served_reg[srv_reg] + SRV_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                last_finish_reg[i] <= '0;
                idle_acc_reg[i]    <= '0;
                service_acc_reg[i] <= '0;
                served_reg[i]      <= '0;
            end
        end
        else
        begin
            if (ctl.wr_svc)
                service_acc_reg[head_idx] <= unit_sum;
            if (ctl.wr_gap)
            begin
                idle_acc_reg[srv_reg]    <= unit_sum;
                last_finish_reg[srv_reg] <= finish_reg;
                served_reg[srv_reg]      <= served_inc;
            end
            if (ctl.wr_rpt)
                idle_acc_reg[ctl.row] <= unit_sum;
        end
    end

    always_comb
    begin
        id_next          = '0;
        idle_out_next    = '0;
        service_out_next = '0;
        served_out_next  = '0;
        case (ctl.out_status)
            STAT_ASSIGNED:
            begin
                id_next          = srv_reg;
                idle_out_next    = unit_sum;
                service_out_next = service_acc_reg[srv_reg];
                served_out_next  = served_inc;
            end
            STAT_REPORT:
            begin
                id_next          = ctl.row;
                idle_out_next    = unit_sum;
                service_out_next = service_acc_reg[ctl.row];
                served_out_next  = served_reg[ctl.row];
            end
            STAT_RELEASED, STAT_REJECTED:
                id_next = sidx_reg;
            default:
                id_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (ctl.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            status_reg      <= ctl.out_status;
            id_reg          <= id_next;
            idle_out_reg    <= idle_out_next;
            service_out_reg <= service_out_next;
            served_out_reg  <= served_out_next;
            last_reg        <= ctl.out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b0, served_out_reg, service_out_reg, idle_out_reg, id_reg};

    `ASSERT_IMPL(a_free_within_count, 1'b1, free_count <= count_reg, "free count above server count")
    `ASSERT_IMPL(a_pop_not_empty, ctl.pop, free_count != '0, "pop from empty free list")
    `ASSERT_IMPL(a_load_slot_free, ctl.out_load, !m_tvalid_reg || m_tready, "result overwritten")
    `ASSERT_NEXT(a_push_counts, ctl.push && !cfg_accept, free_count == $past(free_count) + CNT_W'(1), "release not counted")

endmodule

FILE: tb/pool_monitor.sv
module pool_monitor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [3:0]   cfg_data,
    output int           fails,
    output int           pending
);
    import spfl_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic [IDX_W-1:0]         id;
        logic signed [ACC_W-1:0]  idle;
        logic signed [ACC_W-1:0]  busy;
        logic [SRV_W-1:0]         served;
        logic                     last;
    } row_t;

    row_t rows_due[$];
    int   shown;

    // pool model
    logic [CNT_W-1:0]        n_active;
    logic [IDX_W-1:0]        free_ids [NUM_SERVERS];
    logic [IDX_W-1:0]        head;
    logic [IDX_W-1:0]        tail;
    logic [CNT_W-1:0]        n_free;
    logic [TIME_W-1:0]       finish_at [NUM_SERVERS];
    logic signed [ACC_W-1:0] idle_sum [NUM_SERVERS];
    logic signed [ACC_W-1:0] busy_sum [NUM_SERVERS];
    logic [SRV_W-1:0]        served [NUM_SERVERS];

    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] acc,
                                                          input longint delta);
        longint s;
        s = longint'(acc) + delta;
        if (s > longint'(ACC_MAX))
            return ACC_MAX;
        if (s < longint'(ACC_MIN))
            return ACC_MIN;
        return s[ACC_W-1:0];
    endfunction

    function automatic void refill_free_list();
        for (int i = 0; i < NUM_SERVERS; i++)
            free_ids[i] = (i < n_active) ? IDX_W'(i) : '0;
        head   = '0;
        tail   = n_active[IDX_W-1:0];
        n_free = n_active;
    endfunction

    function automatic void queue_row(input status_t st, input logic [IDX_W-1:0] id,
                                      input bit stats, input bit last);
        row_t r;
        r.status = st;
        r.id     = id;
        r.idle   = stats ? idle_sum[id] : '0;
        r.busy   = stats ? busy_sum[id] : '0;
        r.served = stats ? served[id] : '0;
        r.last   = last;
        rows_due.push_back(r);
    endfunction

    function automatic void run_command(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                                        input logic [TIME_W-1:0] st,
                                        input logic [TIME_W-1:0] ft,
                                        input logic [TIME_W-1:0] rt);
        logic [IDX_W-1:0] s;
        case (cmd)
            CMD_ASSIGN:
            begin
                if (n_free == 0)
                begin
                    queue_row(STAT_NONE_FREE, '0, 1'b0, 1'b1);
                end
                else
                begin
                    s = free_ids[head];
                    head++;
                    n_free--;
                    busy_sum[s]  = sat_sum(busy_sum[s], longint'(ft) - longint'(st));
                    idle_sum[s]  = sat_sum(idle_sum[s], longint'(st) - longint'(finish_at[s]));
                    finish_at[s] = ft;
                    if (served[s] != SRV_MAX)
                        served[s]++;
                    queue_row(STAT_ASSIGNED, s, 1'b1, 1'b1);
                end
            end
            CMD_RELEASE:
            begin
                if ({1'b0, idx} >= n_active || n_free >= n_active)
                begin
                    queue_row(STAT_REJECTED, idx, 1'b0, 1'b1);
                end
                else
                begin
                    free_ids[tail] = idx;
                    tail++;
                    n_free++;
                    queue_row(STAT_RELEASED, idx, 1'b0, 1'b1);
                end
            end
            CMD_REPORT:
            begin
                for (int i = 0; i < n_active; i++)
                begin
                    idle_sum[i] = sat_sum(idle_sum[i], longint'(rt) - longint'(finish_at[i]));
                    queue_row(STAT_REPORT, IDX_W'(i), 1'b1, i + 1 == n_active);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        row_t got;
        row_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                finish_at[i] = '0;
                idle_sum[i]  = '0;
                busy_sum[i]  = '0;
                served[i]    = '0;
            end
            n_active = CNT_W'(NUM_SERVERS);
            refill_free_list();
            rows_due.delete();
            fails   = 0;
            pending = 0;
            shown   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data == '0)
                    n_active = CNT_W'(1);
                else if (cfg_data > NUM_SERVERS)
                    n_active = CNT_W'(NUM_SERVERS);
                else
                    n_active = cfg_data;
                refill_free_list();
            end
            if (s_tvalid && s_tready)
                run_command(cmd_t'(s_tuser), s_tdata[2:0], s_tdata[34:3],
                            s_tdata[66:35], s_tdata[98:67]);
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.id     = m_tdata[2:0];
                got.idle   = m_tdata[50:3];
                got.busy   = m_tdata[98:51];
                got.served = m_tdata[130:99];
                got.last   = m_tlast;
                if (rows_due.size() == 0)
                begin
                    fails++;
                    if (shown < 10)
                        $display("unexpected result: status=%0d id=%0d last=%0b",
                                 got.status, got.id, got.last);
                    shown++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (shown < 10)
                        begin
                            $display("mismatch want: status=%0d id=%0d idle=%0d svc=%0d n=%0d last=%0b",
                                     want.status, want.id, want.idle, want.busy,
                                     want.served, want.last);
                            $display("          got: status=%0d id=%0d idle=%0d svc=%0d n=%0d last=%0b",
                                     got.status, got.id, got.idle, got.busy,
                                     got.served, got.last);
                        end
                        shown++;
                    end
                end
            end
            pending = rows_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
module tb;
    import spfl_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int FAST_ROUNDS   = 8;
    localparam int PHASE_ITEMS   = 57;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic [103:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tready  = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [3:0]   cfg_data  = '0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [135:0] m_tdata;
    wire  [2:0]   m_tuser;
    wire          m_tlast;
    wire          cfg_ready;
    int           fails;
    int           pending;

    int          burst_left  = 0;
    bit          hurry       = 1'b0;
    int          holds_asked = 0;
    int          live        = NUM_SERVERS;
    logic [31:0] now_t       = '0;

    server_pool_free_list_with_stats DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pool_monitor u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // one command transaction; gaps only between bursts
    task automatic offer(input cmd_t cmd, input logic [2:0] idx, input logic [31:0] st,
                         input logic [31:0] ft, input logic [31:0] rt);
        int gap;
        if (!hurry)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, rt, ft, st, idx};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_count(input logic [3:0] v);
        quiesce();
        // a nop may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        live = (v == 0) ? 1 : ((v > NUM_SERVERS) ? NUM_SERVERS : int'(v));
    endtask

    task automatic random_command(output bit counted);
        int          pick;
        cmd_t        c;
        logic [2:0]  idx;
        logic [31:0] st;
        logic [31:0] ft;
        logic [31:0] rt;
        pick = $urandom_range(0, 99);
        c = (pick < 45) ? CMD_ASSIGN : (pick < 80) ? CMD_RELEASE :
            (pick < 93) ? CMD_REPORT : CMD_NOP;
        if ($urandom_range(0, 4) == 0)
            idx = 3'($urandom_range(0, 7));
        else
            idx = 3'($urandom_range(0, live - 1));
        if ($urandom_range(0, 9) == 0)
        begin
            st = $urandom;
            ft = $urandom;
            rt = $urandom;
        end
        else
        begin
            // plausible timeline: start after now, finish after start
            st    = now_t + $urandom_range(0, 32'h4_0000);
            ft    = st + $urandom_range(0, 32'h8_0000);
            rt    = ft + $urandom_range(0, 32'h1_0000);
            now_t = st + $urandom_range(0, 32'h2_0000);
        end
        offer(c, idx, st, ft, rt);
        counted = (c != CMD_NOP);
    endtask

    // receiver: stall patterns of its own, plus long hold-offs on request
    initial
    begin : receiver
        int   mode;
        int   left;
        int   holds_done;
        logic rdy;
        mode       = 0;
        left       = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 60);
                end
                left--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ~m_tready;
                endcase
                m_tready <= hurry ? 1'b1 : rdy;
            end
        end
    end

    initial
    begin : stimulus
        int          done;
        bit          counted;
        logic [3:0]  counts [6];
        counts = '{4'd8, 4'd3, 4'd15, 4'd5, 4'd1, 4'd0};
        counts[5] = 4'($urandom_range(0, 15));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all eight servers after reset
        offer(CMD_ASSIGN, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        offer(CMD_ASSIGN, 3'd7, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        offer(CMD_ASSIGN, 3'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        offer(CMD_ASSIGN, 3'd0, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
        // report earlier than some finishes: negative idle
        offer(CMD_REPORT, 3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        offer(CMD_RELEASE, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(CMD_RELEASE, 3'd1, 32'h0, 32'h0, 32'h0);   // already free, queued again
        offer(CMD_RELEASE, 3'd7, 32'h0, 32'h0, 32'h0);
        offer(CMD_RELEASE, 3'd0, 32'h0, 32'h0, 32'h0);
        offer(CMD_RELEASE, 3'd3, 32'h0, 32'h0, 32'h0);   // list already full: rejected
        offer(CMD_NOP, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (9)
            offer(CMD_ASSIGN, 3'd5, 32'h0004_0000, 32'h0005_8000, 32'h0);
        offer(CMD_REPORT, 3'd2, 32'h0, 32'h0, 32'hFFFF_FFFF);

        // zero clamps to a single server
        set_count(4'd0);
        offer(CMD_ASSIGN, 3'd0, 32'h0010_0000, 32'h0011_0000, 32'h0);
        offer(CMD_ASSIGN, 3'd0, 32'h0012_0000, 32'h0013_0000, 32'h0);
        offer(CMD_RELEASE, 3'd5, 32'h0, 32'h0, 32'h0);   // out of range
        offer(CMD_RELEASE, 3'd0, 32'h0, 32'h0, 32'h0);
        offer(CMD_RELEASE, 3'd0, 32'h0, 32'h0, 32'h0);
        offer(CMD_REPORT, 3'd0, 32'h0, 32'h0, 32'h0020_0000);

        // back-to-back assign/release on one server, receiver always ready
        set_count(4'd1);
        hurry = 1'b1;
        repeat (FAST_ROUNDS)
        begin
            offer(CMD_ASSIGN, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
            offer(CMD_RELEASE, 3'd0, 32'h0, 32'h0, 32'h0);
        end
        offer(CMD_REPORT, 3'd0, 32'h0, 32'h0, 32'h0);
        offer(CMD_ASSIGN, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0);
        hurry = 1'b0;

        for (int p = 0; p < 6; p++)
        begin
            set_count(counts[p]);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                random_command(counted);
                if (counted)
                begin
                    done++;
                    if (p == 1 && done == 20)
                        holds_asked++;
                    if (p == 3 && done == 35)
                        quiesce();
                end
            end
        end

        quiesce();
        repeat (30) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
